// ===== design/rdsnt_pkg.sv =====
// Shared types, constants and helper functions of the RDS name and text decoder.
// Used by the controller, the datapath and the top level.
package rdsnt_pkg;

  localparam int NAME_CHARS = 8;
  localparam int TEXT_CHARS = 64;
  localparam int ROW_CHARS  = 8;
  localparam int TEXT_ROWS  = TEXT_CHARS / ROW_CHARS;
  localparam int ROW_W      = $clog2(TEXT_ROWS);
  localparam int COL_W      = $clog2(ROW_CHARS);
  localparam int POS_W      = $clog2(TEXT_CHARS);
  localparam int LEN_W      = POS_W + 1;
  localparam int NLEN_W     = $clog2(NAME_CHARS) + 1;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;

  localparam logic [3:0] GTYPE_NAME = 4'd0;
  localparam logic [3:0] GTYPE_TEXT = 4'd2;

  typedef logic [8*ROW_CHARS-1:0] row_t;

  localparam row_t SPACE_ROW = {ROW_CHARS{SPACE_CHAR}};

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_NAME,
    ST_SCAN,
    ST_PUBLISH,
    ST_EMIT_ONE,
    ST_EMIT_TEXT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load;
    logic             update;
    logic             pub_name;
    logic             scan;
    logic             pub_text;
    logic             emit;
    logic [ROW_W-1:0] row;
    logic             last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic grp_name;
    logic grp_text;
    logic out_free;
  } stat_t;

  // Map a received byte to itself when printable, to a space otherwise.
  function automatic logic [7:0] sanitize(input logic [7:0] b);
    return (b >= PRINT_LO && b <= PRINT_HI) ? b : SPACE_CHAR;
  endfunction

  // Bit i set when byte i (byte 0 in the top byte) is not a space.
  function automatic logic [ROW_CHARS-1:0] nonspace_mask(input row_t r);
    logic [ROW_CHARS-1:0] m;
    for (int i = 0; i < ROW_CHARS; i++) begin
      m[i] = (r[8*ROW_CHARS-1-8*i -: 8] != SPACE_CHAR);
    end
    return m;
  endfunction

  function automatic logic [COL_W-1:0] first_set(input logic [ROW_CHARS-1:0] m);
    logic [COL_W-1:0] f;
    f = '0;
    for (int i = ROW_CHARS - 1; i >= 0; i--) begin
      if (m[i]) f = COL_W'(i);
    end
    return f;
  endfunction

  function automatic logic [COL_W-1:0] last_set(input logic [ROW_CHARS-1:0] m);
    logic [COL_W-1:0] l;
    l = '0;
    for (int i = 0; i < ROW_CHARS; i++) begin
      if (m[i]) l = COL_W'(i);
    end
    return l;
  endfunction

endpackage

// ===== design/rdsnt_if.sv =====
// Valid/ready channel interfaces for RDS groups in and decoded results out.
// Depends on nothing but the field widths of the decoder.
interface rdsnt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_a;
  logic [15:0] block_b;
  logic [15:0] block_c;
  logic [15:0] block_d;

  modport source (output valid, output block_a, output block_b, output block_c,
                  output block_d, input ready);
  modport sink (input valid, input block_a, input block_b, input block_c,
                input block_d, output ready);
endinterface

interface rdsnt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        station_known;
  logic [63:0] station_chars;
  logic [3:0]  station_length;
  logic [2:0]  slice_index;
  logic [63:0] slice_chars;
  logic [5:0]  text_start;
  logic [6:0]  text_length;
  logic        program_changed;
  logic        text_flag_flipped;
  logic        last;

  modport source (output valid, output kind, output station_known,
                  output station_chars, output station_length, output slice_index,
                  output slice_chars, output text_start, output text_length,
                  output program_changed, output text_flag_flipped, output last,
                  input ready);
  modport sink (input valid, input kind, input station_known, input station_chars,
                input station_length, input slice_index, input slice_chars,
                input text_start, input text_length, input program_changed,
                input text_flag_flipped, input last, output ready);
endinterface

// ===== design/rdsnt_ctrl.sv =====
// Sequencing state machine of the RDS name and text decoder.
// Depends on rdsnt_pkg; drives the datapath through cmd_t, watches stat_t.
module rdsnt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rdsnt_pkg::stat_t st,
  output rdsnt_pkg::cmd_t  cmd
);

  localparam logic [rdsnt_pkg::ROW_W-1:0] ROW_MAX =
    rdsnt_pkg::ROW_W'(rdsnt_pkg::TEXT_ROWS - 1);

  rdsnt_pkg::state_t state_r, state_nxt;
  logic [rdsnt_pkg::ROW_W-1:0] row_r, row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdsnt_pkg::ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    case (state_r)
      rdsnt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rdsnt_pkg::ST_UPDATE;
      end
      rdsnt_pkg::ST_UPDATE: begin
        row_nxt = '0;
        if (st.grp_name)      state_nxt = rdsnt_pkg::ST_NAME;
        else if (st.grp_text) state_nxt = rdsnt_pkg::ST_SCAN;
        else                  state_nxt = rdsnt_pkg::ST_EMIT_ONE;
      end
      rdsnt_pkg::ST_NAME: begin
        state_nxt = rdsnt_pkg::ST_EMIT_ONE;
      end
      rdsnt_pkg::ST_SCAN: begin
        row_nxt = row_r + 1'b1;
        if (row_r == ROW_MAX) state_nxt = rdsnt_pkg::ST_PUBLISH;
      end
      rdsnt_pkg::ST_PUBLISH: begin
        state_nxt = rdsnt_pkg::ST_EMIT_TEXT;
      end
      rdsnt_pkg::ST_EMIT_ONE: begin
        if (st.out_free) state_nxt = rdsnt_pkg::ST_IDLE;
      end
      rdsnt_pkg::ST_EMIT_TEXT: begin
        if (st.out_free) begin
          row_nxt = row_r + 1'b1;
          if (row_r == ROW_MAX) state_nxt = rdsnt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rdsnt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.row      = row_r;
    in_ready     = 1'b0;
    case (state_r)
      rdsnt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rdsnt_pkg::ST_UPDATE:  cmd.update   = 1'b1;
      rdsnt_pkg::ST_NAME:    cmd.pub_name = 1'b1;
      rdsnt_pkg::ST_SCAN:    cmd.scan     = 1'b1;
      rdsnt_pkg::ST_PUBLISH: cmd.pub_text = 1'b1;
      rdsnt_pkg::ST_EMIT_ONE: begin
        cmd.emit = st.out_free;
        cmd.last = 1'b1;
      end
      rdsnt_pkg::ST_EMIT_TEXT: begin
        cmd.emit = st.out_free;
        cmd.last = (row_r == ROW_MAX);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.update, cmd.pub_name, cmd.scan, cmd.pub_text, cmd.emit}))
    else $error("more than one datapath command at once");

  a_text_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rdsnt_pkg::ST_EMIT_TEXT && st.out_free && row_r == ROW_MAX)
    |=> state_r == rdsnt_pkg::ST_IDLE)
    else $error("text run did not end after the final slice");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rdsnt_pkg::ST_UPDATE && st.grp_text)
    |=> (state_r == rdsnt_pkg::ST_SCAN && row_r == '0))
    else $error("text scan did not start at the first row");

endmodule

// ===== design/rdsnt_dp.sv =====
// Datapath of the RDS name and text decoder: stores, trim scan and result register.
// Depends on rdsnt_pkg and rdsnt_out_if; commanded by rdsnt_ctrl.
module rdsnt_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  rdsnt_pkg::cmd_t cmd,
  output rdsnt_pkg::stat_t st,
  input  logic [15:0]     block_a,
  input  logic [15:0]     block_b,
  input  logic [15:0]     block_c,
  input  logic [15:0]     block_d,
  rdsnt_out_if.source     out_res
);

  // Captured group.
  logic [15:0] blk_a_r, blk_b_r, blk_c_r, blk_d_r;

  // Decoder state.
  logic [15:0]                       last_code_r;
  logic                              code_seen_r;
  logic                              flag_r;
  logic                              flag_seen_r;
  rdsnt_pkg::row_t                   name_r;
  rdsnt_pkg::row_t                   text_r [rdsnt_pkg::TEXT_ROWS];
  rdsnt_pkg::row_t                   pub_name_r;
  logic [rdsnt_pkg::NLEN_W-1:0]      pub_nlen_r;
  logic                              pub_known_r;
  rdsnt_pkg::row_t                   pub_text_r [rdsnt_pkg::TEXT_ROWS];
  logic [rdsnt_pkg::POS_W-1:0]       pub_start_r;
  logic [rdsnt_pkg::LEN_W-1:0]       pub_len_r;

  // Per-group flags and scan accumulators.
  logic                              pc_r, ff_r;
  logic                              found_r;
  logic [rdsnt_pkg::POS_W-1:0]       scan_start_r;
  logic [rdsnt_pkg::LEN_W-1:0]       scan_end_r;

  // Result register.
  logic                              out_valid_r;
  rdsnt_pkg::kind_t                  o_kind_r;
  logic                              o_known_r;
  rdsnt_pkg::row_t                   o_name_r;
  logic [rdsnt_pkg::NLEN_W-1:0]      o_nlen_r;
  logic [rdsnt_pkg::ROW_W-1:0]       o_slice_r;
  rdsnt_pkg::row_t                   o_chars_r;
  logic [rdsnt_pkg::POS_W-1:0]       o_start_r;
  logic [rdsnt_pkg::LEN_W-1:0]       o_len_r;
  logic                              o_pc_r, o_ff_r, o_last_r;

  logic [3:0]                  gtype;
  logic                        grp_name, grp_text;
  logic                        pc, ff, flag, ver_b;
  logic [3:0]                  seg;
  logic [7:0]                  c_hi, c_lo, d_hi, d_lo;
  logic [rdsnt_pkg::ROW_W-1:0] wrow;
  rdsnt_pkg::row_t             text_base, text_wr, name_base, name_wr;
  rdsnt_pkg::kind_t            kind;

  logic [rdsnt_pkg::ROW_CHARS-1:0] scan_mask, name_mask;
  rdsnt_pkg::row_t                 scan_row;
  logic [rdsnt_pkg::POS_W-1:0]     row_first_pos;
  logic [rdsnt_pkg::LEN_W-1:0]     row_end_pos;

  assign gtype    = blk_b_r[15:12];
  assign grp_name = (gtype == rdsnt_pkg::GTYPE_NAME);
  assign grp_text = (gtype == rdsnt_pkg::GTYPE_TEXT);
  assign kind     = grp_name ? rdsnt_pkg::KIND_NAME :
                    grp_text ? rdsnt_pkg::KIND_TEXT : rdsnt_pkg::KIND_IGNORED;

  // A new program code wipes everything, so the flip test then sees no old flag.
  assign pc    = code_seen_r && (blk_a_r != last_code_r);
  assign flag  = blk_b_r[4];
  assign ver_b = blk_b_r[11];
  assign seg   = blk_b_r[3:0];
  assign ff    = grp_text && flag_seen_r && !pc && (flag != flag_r);

  assign c_hi = rdsnt_pkg::sanitize(blk_c_r[15:8]);
  assign c_lo = rdsnt_pkg::sanitize(blk_c_r[7:0]);
  assign d_hi = rdsnt_pkg::sanitize(blk_d_r[15:8]);
  assign d_lo = rdsnt_pkg::sanitize(blk_d_r[7:0]);

  // Version B puts two characters at seg*2, version A four at seg*4.
  assign wrow = ver_b ? {1'b0, seg[3:2]} : seg[3:1];

  always_comb begin
    text_base = (pc || ff) ? rdsnt_pkg::SPACE_ROW : text_r[wrow];
    text_wr   = text_base;
    for (int i = 0; i < rdsnt_pkg::ROW_CHARS; i++) begin
      if (ver_b) begin
        if (rdsnt_pkg::COL_W'(i) == {seg[1:0], 1'b0}) text_wr[63-8*i -: 8] = d_hi;
        if (rdsnt_pkg::COL_W'(i) == {seg[1:0], 1'b1}) text_wr[63-8*i -: 8] = d_lo;
      end else begin
        if (rdsnt_pkg::COL_W'(i) == {seg[0], 2'b00}) text_wr[63-8*i -: 8] = c_hi;
        if (rdsnt_pkg::COL_W'(i) == {seg[0], 2'b01}) text_wr[63-8*i -: 8] = c_lo;
        if (rdsnt_pkg::COL_W'(i) == {seg[0], 2'b10}) text_wr[63-8*i -: 8] = d_hi;
        if (rdsnt_pkg::COL_W'(i) == {seg[0], 2'b11}) text_wr[63-8*i -: 8] = d_lo;
      end
    end
  end

  always_comb begin
    name_base = pc ? rdsnt_pkg::SPACE_ROW : name_r;
    name_wr   = name_base;
    for (int i = 0; i < rdsnt_pkg::NAME_CHARS; i++) begin
      if (rdsnt_pkg::COL_W'(i) == {blk_b_r[1:0], 1'b0}) name_wr[63-8*i -: 8] = d_hi;
      if (rdsnt_pkg::COL_W'(i) == {blk_b_r[1:0], 1'b1}) name_wr[63-8*i -: 8] = d_lo;
    end
  end

  assign scan_row      = text_r[cmd.row];
  assign scan_mask     = rdsnt_pkg::nonspace_mask(scan_row);
  assign row_first_pos = {cmd.row, rdsnt_pkg::first_set(scan_mask)};
  assign row_end_pos   = rdsnt_pkg::LEN_W'({cmd.row, rdsnt_pkg::last_set(scan_mask)}) + 1'b1;
  assign name_mask     = rdsnt_pkg::nonspace_mask(name_r);

  assign st.grp_name = grp_name;
  assign st.grp_text = grp_text;
  assign st.out_free = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_a_r <= block_a;
      blk_b_r <= block_b;
      blk_c_r <= block_c;
      blk_d_r <= block_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_code_r  <= '0;
      code_seen_r  <= 1'b0;
      flag_r       <= 1'b0;
      flag_seen_r  <= 1'b0;
      name_r       <= rdsnt_pkg::SPACE_ROW;
      pub_name_r   <= rdsnt_pkg::SPACE_ROW;
      pub_nlen_r   <= '0;
      pub_known_r  <= 1'b0;
      pub_start_r  <= '0;
      pub_len_r    <= '0;
      pc_r         <= 1'b0;
      ff_r         <= 1'b0;
      found_r      <= 1'b0;
      scan_start_r <= '0;
      scan_end_r   <= '0;
      for (int k = 0; k < rdsnt_pkg::TEXT_ROWS; k++) begin
        text_r[k]     <= rdsnt_pkg::SPACE_ROW;
        pub_text_r[k] <= rdsnt_pkg::SPACE_ROW;
      end
    end else begin
      if (cmd.update) begin
        pc_r        <= pc;
        ff_r        <= ff;
        found_r     <= 1'b0;
        code_seen_r <= 1'b1;
        last_code_r <= blk_a_r;
        // Drop everything published on a program change.
        if (pc) begin
          pub_name_r  <= rdsnt_pkg::SPACE_ROW;
          pub_nlen_r  <= '0;
          pub_known_r <= 1'b0;
          pub_start_r <= '0;
          pub_len_r   <= '0;
          for (int k = 0; k < rdsnt_pkg::TEXT_ROWS; k++) begin
            pub_text_r[k] <= rdsnt_pkg::SPACE_ROW;
          end
        end
        // A text group records its flag; a program change alone forgets it.
        if (grp_text) begin
          flag_r      <= flag;
          flag_seen_r <= 1'b1;
        end else if (pc) begin
          flag_r      <= 1'b0;
          flag_seen_r <= 1'b0;
        end
        // Write the addressed row; blank the other rows on a clear.
        for (int k = 0; k < rdsnt_pkg::TEXT_ROWS; k++) begin
          if (grp_text && (wrow == rdsnt_pkg::ROW_W'(k))) begin
            text_r[k] <= text_wr;
          end else if (pc || ff) begin
            text_r[k] <= rdsnt_pkg::SPACE_ROW;
          end
        end
        name_r <= grp_name ? name_wr : name_base;
      end

      if (cmd.pub_name && (name_mask != '0)) begin
        pub_name_r  <= name_r;
        pub_nlen_r  <= rdsnt_pkg::NLEN_W'(rdsnt_pkg::last_set(name_mask)) + 1'b1;
        pub_known_r <= 1'b1;
      end

      if (cmd.scan && (scan_mask != '0)) begin
        found_r    <= 1'b1;
        scan_end_r <= row_end_pos;
        if (!found_r) scan_start_r <= row_first_pos;
      end

      if (cmd.pub_text && found_r) begin
        pub_start_r <= scan_start_r;
        pub_len_r   <= scan_end_r - rdsnt_pkg::LEN_W'(scan_start_r);
        for (int k = 0; k < rdsnt_pkg::TEXT_ROWS; k++) begin
          pub_text_r[k] <= text_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kind_r  <= kind;
      o_known_r <= pub_known_r;
      o_name_r  <= pub_name_r;
      o_nlen_r  <= pub_nlen_r;
      o_slice_r <= grp_text ? cmd.row : '0;
      o_chars_r <= grp_text ? pub_text_r[cmd.row] : '0;
      o_start_r <= pub_start_r;
      o_len_r   <= pub_len_r;
      o_pc_r    <= pc_r;
      o_ff_r    <= ff_r;
      o_last_r  <= cmd.last;
    end
  end

  assign out_res.valid             = out_valid_r;
  assign out_res.kind              = o_kind_r;
  assign out_res.station_known     = o_known_r;
  assign out_res.station_chars     = o_name_r;
  assign out_res.station_length    = o_nlen_r;
  assign out_res.slice_index       = o_slice_r;
  assign out_res.slice_chars       = o_chars_r;
  assign out_res.text_start        = o_start_r;
  assign out_res.text_length       = o_len_r;
  assign out_res.program_changed   = o_pc_r;
  assign out_res.text_flag_flipped = o_ff_r;
  assign out_res.last              = o_last_r;

  a_text_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (rdsnt_pkg::LEN_W'(pub_start_r) + pub_len_r) <= rdsnt_pkg::LEN_W'(rdsnt_pkg::TEXT_CHARS))
    else $error("published text runs past the store");

  a_name_known: assert property (@(posedge clk) disable iff (!rst_n)
    (pub_nlen_r != '0) == pub_known_r)
    else $error("published name length disagrees with known flag");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (scan_end_r > rdsnt_pkg::LEN_W'(scan_start_r)))
    else $error("text scan end not past its start");

endmodule

// ===== design/rds_name_and_text_decoder.sv =====
// Top level of the RDS program-service name and radiotext decoder.
// Depends on rdsnt_pkg, rdsnt_if, rdsnt_ctrl and rdsnt_dp.
//
// Usage:
//   in_grp carries one RDS group per beat (blocks A..D). out_res carries the
//   decoded results. Group type 0 yields one name beat, group type 2 yields a
//   run of eight text-slice beats (slice 0..7, last on slice 7), any other
//   group yields one beat of kind "ignored".
//   Throughput: one group at a time. A name group goes through update,
//   publish and emit until its result sits in the output register, an
//   ignored group through update and emit; the controller is then idle and
//   accepts the next group. A text group goes through update, a trim scan of
//   the text store (one 8-character row per cycle), publish and one emit per
//   slice; its first slice is registered by the first emit after publish.
//   in_grp.ready is high only while the controller is idle.
//   Reset (rst_n low, synchronous) clears the program code, the A/B flag and
//   fills both stores and the published copies with spaces.
//   When the receiver stalls, the result register holds its beat and the
//   sequencer waits in its emit state; a finished final beat may still wait
//   while the next group is accepted and processed.
module rds_name_and_text_decoder (
  input  logic       clk,
  input  logic       rst_n,
  rdsnt_in_if.sink   in_grp,
  rdsnt_out_if.source out_res
);

  rdsnt_pkg::cmd_t  cmd;
  rdsnt_pkg::stat_t st;

  // Sequencer: owns the state and the row counter.
  rdsnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_grp.valid),
    .in_ready (in_grp.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Stores, trim scan, publish copies and the result register.
  rdsnt_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .st      (st),
    .block_a (in_grp.block_a),
    .block_b (in_grp.block_b),
    .block_c (in_grp.block_c),
    .block_d (in_grp.block_d),
    .out_res (out_res)
  );

endmodule
